[src/link_loss_failsafe_governor_core_macros.svh]
// assertion macros for the failsafe governor
`ifndef LINK_LOSS_FAILSAFE_GOVERNOR_CORE_MACROS_SVH
`define LINK_LOSS_FAILSAFE_GOVERNOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LLFG_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("governor assertion failed");
// next-cycle implication
`define LLFG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("governor assertion failed");
`else
`define LLFG_ASSERT_NOW(label, clk, rst, ante, cons)
`define LLFG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/llfg_pkg.sv]
`timescale 1ns / 1ps
package llfg_pkg;

  // failsafe levels
  localparam logic [1:0] LVL_NONE = 2'd0;
  localparam logic [1:0] LVL_WARN = 2'd1;
  localparam logic [1:0] LVL_LAND = 2'd2;
  localparam logic [1:0] LVL_KILL = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_AFTER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAND_AFTER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KILL_AFTER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAND_DUR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LAND_START   = 3'd4;

  // register reset values
  localparam logic [15:0] WARN_AFTER_RST = 16'd100;
  localparam logic [15:0] LAND_AFTER_RST = 16'd500;
  localparam logic [15:0] KILL_AFTER_RST = 16'd2000;
  localparam logic [15:0] LAND_DUR_RST   = 16'd8000;
  localparam logic [15:0] LAND_START_RST = 16'd32768;

  // ramp divider: one quotient bit per step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [31:0] now_ms;
    logic        link_up;
    logic        battery_critical;
    logic        armed;
    logic [15:0] pilot_throttle;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  level;
    logic        failsafe_active;
    logic [15:0] throttle_out;
    logic        disarm_request;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic upd;
    logic qry;
    logic mul;
    logic div;
    logic load_out;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;
    logic div_last;
  } dp_status_t;

endpackage

[src/link_loss_failsafe_governor_core.sv]
`timescale 1ns / 1ps
// channel  | signals                         | word
// ---------+---------------------------------+-------------------------------
// input    | in_valid, in_ready, in_data     | in_word_t: time, link, battery
// output   | out_valid, out_ready, out_data  | out_word_t: level, throttle
// config   | cfg_we, cfg_index, cfg_data     | 16-bit register write
//
// a word passes through update, throttle query and output load when no ramp is
// running; during a landing ramp a multiply and the 16-step serial ramp divider
// run between the query and the output load
// in_ready is high only while the sequencer is idle; a waiting result does not
// block the next word, but that word's result waits until the output is taken
// rst is synchronous: state, level and configuration registers return to their reset values
module link_loss_failsafe_governor_core
  import llfg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  llfg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // levels, timers and ramp divider
  llfg_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule

[src/llfg_datapath.sv]
`timescale 1ns / 1ps
`include "link_loss_failsafe_governor_core_macros.svh"
module llfg_datapath
  import llfg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  in_word_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output out_word_t            out_data
);

  logic [15:0] warn_after;
  logic [15:0] land_after;
  logic [15:0] kill_after;
  logic [15:0] land_dur;
  logic [15:0] land_start;

  in_word_t    in_q;
  logic [1:0]  fs_level;
  logic [31:0] last_link_ms;
  logic        ever_linked;
  logic [31:0] landing_start_ms;
  logic        disarm;
  logic [15:0] thr;
  logic [15:0] rem;
  logic [15:0] quo;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic [1:0]  lvl_next;
  logic [31:0] ls_next;
  logic        dis_upd;
  logic [31:0] lost;
  logic        lost_kill, lost_land, lost_warn;
  logic [31:0] elapsed;
  logic        ramp_done;
  logic [15:0] remain;
  logic [16:0] trial;
  logic        trial_ge;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_after <= WARN_AFTER_RST;
      land_after <= LAND_AFTER_RST;
      kill_after <= KILL_AFTER_RST;
      land_dur   <= LAND_DUR_RST;
      land_start <= LAND_START_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WARN_AFTER: warn_after <= cfg_data;
        REG_LAND_AFTER: land_after <= cfg_data;
        REG_KILL_AFTER: kill_after <= cfg_data;
        REG_LAND_DUR:   land_dur   <= cfg_data;
        REG_LAND_START: land_start <= cfg_data;
        default: ;
      endcase
    end
  end

  // link-loss time against the 16-bit thresholds
  assign lost      = in_q.now_ms - last_link_ms;
  assign lost_kill = (lost[31:16] != 16'd0) || (lost[15:0] >= kill_after);
  assign lost_land = (lost[31:16] != 16'd0) || (lost[15:0] >= land_after);
  assign lost_warn = (lost[31:16] != 16'd0) || (lost[15:0] >= warn_after);

  // level update: battery check, then link watchdog
  always_comb begin
    lvl_next = fs_level;
    ls_next  = landing_start_ms;
    dis_upd  = 1'b0;
    if (in_q.battery_critical && in_q.armed && (fs_level < LVL_LAND)) begin
      lvl_next = LVL_LAND;
      ls_next  = in_q.now_ms;
    end
    if (in_q.link_up) begin
      if (lvl_next == LVL_WARN) begin
        lvl_next = LVL_NONE;
      end
    end else if (ever_linked) begin
      priority if (lost_kill && (lvl_next < LVL_KILL)) begin
        lvl_next = LVL_KILL;
        dis_upd  = 1'b1;
      end else if (lost_land && (lvl_next < LVL_LAND)) begin
        lvl_next = LVL_LAND;
        ls_next  = in_q.now_ms;
      end else if (lost_warn && (lvl_next < LVL_WARN)) begin
        lvl_next = LVL_WARN;
      end
    end
  end

  // ramp position
  assign elapsed   = in_q.now_ms - landing_start_ms;
  assign ramp_done = (elapsed[31:16] != 16'd0) || (elapsed[15:0] >= land_dur);
  assign remain    = land_dur - elapsed[15:0];

  assign status.need_div = (fs_level == LVL_LAND) && !ramp_done;
  assign status.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  // restoring division step
  assign trial    = {rem, quo[15]};
  assign trial_ge = (trial >= {1'b0, land_dur});

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_level         <= LVL_NONE;
      last_link_ms     <= 32'd0;
      ever_linked      <= 1'b0;
      landing_start_ms <= 32'd0;
      disarm           <= 1'b0;
    end else begin
      if (cmd.upd) begin
        fs_level         <= lvl_next;
        landing_start_ms <= ls_next;
        disarm           <= dis_upd;
        if (in_q.link_up) begin
          ever_linked  <= 1'b1;
          last_link_ms <= in_q.now_ms;
        end
      end
      if (cmd.qry && (fs_level == LVL_LAND) && ramp_done) begin
        fs_level <= LVL_KILL;
        disarm   <= 1'b1;
      end
    end
  end

  // item word, throttle and divider registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_q <= in_data;
    end
    if (cmd.qry) begin
      unique case (fs_level)
        LVL_KILL: thr <= 16'd0;
        LVL_LAND: thr <= 16'd0;
        default:  thr <= in_q.pilot_throttle;
      endcase
    end
    if (cmd.mul) begin
      {rem, quo} <= {16'd0, land_start} * {16'd0, remain};
      div_cnt    <= '0;
    end
    if (cmd.div) begin
      rem     <= trial_ge ? 16'(trial - {1'b0, land_dur}) : trial[15:0];
      quo     <= {quo[14:0], trial_ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (status.div_last) begin
        thr <= {quo[14:0], trial_ge};
      end
    end
    if (cmd.load_out) begin
      out_data.level           <= fs_level;
      out_data.failsafe_active <= fs_level[1];
      out_data.throttle_out    <= thr;
      out_data.disarm_request  <= disarm;
    end
  end

  // kill is never left
  `LLFG_ASSERT_NEXT(a_kill_sticky, clk, rst, fs_level == LVL_KILL, fs_level == LVL_KILL)
  // a disarm pulse belongs to kill
  `LLFG_ASSERT_NOW(a_disarm_kill, clk, rst, disarm, fs_level == LVL_KILL)
  // partial remainder stays below the divisor
  `LLFG_ASSERT_NOW(a_rem_bound, clk, rst, cmd.div, rem < land_dur)

endmodule

[src/llfg_ctrl.sv]
`timescale 1ns / 1ps
`include "link_loss_failsafe_governor_core_macros.svh"
module llfg_ctrl
  import llfg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_QRY  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // commands per state
  always_comb begin
    cmd          = '0;
    cmd.load_in  = in_valid && in_ready;
    cmd.upd      = (state == ST_UPD);
    cmd.qry      = (state == ST_QRY);
    cmd.mul      = (state == ST_MUL);
    cmd.div      = (state == ST_DIV);
    cmd.load_out = (state == ST_OUT) && out_free;
  end

  // sequencing
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_UPD;
      ST_UPD:  state_next = ST_QRY;
      ST_QRY:  state_next = status.need_div ? ST_MUL : ST_OUT;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (status.div_last) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // an accepted word starts the update
  `LLFG_ASSERT_NEXT(a_accept_upd, clk, rst, in_valid && in_ready, state == ST_UPD)
  // last divider step hands over to the output
  `LLFG_ASSERT_NEXT(a_div_out, clk, rst, state == ST_DIV && status.div_last, state == ST_OUT)
  // leaving the output state always presents a word
  `LLFG_ASSERT_NEXT(a_out_load, clk, rst, cmd.load_out, out_valid && state == ST_IDLE)

endmodule
